// File: rtl/core/qbrc_pkg.sv
package qbrc_pkg;

    // fraction bits of the curve parameter t, and bits of t itself (t spans [0,1])
    localparam int TFRAC = 16;
    localparam int QW    = TFRAC + 1;

    // result word
    localparam int COUNT_W  = 2;
    localparam int M_DATA_W = 8;

    // flags that travel with one root lane
    typedef struct packed {
        logic valid;
        logic live;
    } lane_t;

endpackage

// File: rtl/core/qbrc_setup.sv
module qbrc_setup #(
    parameter int CW = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [8*CW-1:0]      in_data,
    output logic                 out_valid,
    output logic signed [2*CW+4:0] out_disc,
    output logic signed [CW+2:0] out_a,
    output logic signed [CW+1:0] out_h,
    output logic signed [CW:0]   out_c,
    output logic signed [CW:0]   out_x0,
    output logic signed [CW+1:0] out_twohx,
    output logic signed [CW+1:0] out_ax
);

    localparam int AW = CW + 3;
    localparam int HW = CW + 2;
    localparam int YW = CW + 1;
    localparam int XW = CW + 1;
    localparam int TW = CW + 2;
    localparam int PW = 2 * CW + 5;

    logic signed [CW-1:0] sx, sy, cx, cy, ex, ey, px, py;
    logic signed [YW-1:0] y0, y1, y2;

    assign sx = in_data[0*CW +: CW];
    assign sy = in_data[1*CW +: CW];
    assign cx = in_data[2*CW +: CW];
    assign cy = in_data[3*CW +: CW];
    assign ex = in_data[4*CW +: CW];
    assign ey = in_data[5*CW +: CW];
    assign px = in_data[6*CW +: CW];
    assign py = in_data[7*CW +: CW];

    assign y0 = YW'(sy) - YW'(py);
    assign y1 = YW'(cy) - YW'(py);
    assign y2 = YW'(ey) - YW'(py);

    logic                 v1_reg, v2_reg, v3_reg;
    logic signed [AW-1:0] a1_reg, a2_reg, a3_reg;
    logic signed [HW-1:0] h1_reg, h2_reg, h3_reg;
    logic signed [YW-1:0] c1_reg, c2_reg, c3_reg;
    logic signed [XW-1:0] x01_reg, x02_reg, x03_reg;
    logic signed [TW-1:0] thx1_reg, thx2_reg, thx3_reg;
    logic signed [TW-1:0] ax1_reg, ax2_reg, ax3_reg;
    logic signed [2*HW-1:0]  hh2_reg;
    logic signed [AW+YW-1:0] ac2_reg;
    logic signed [PW-1:0] d3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // polynomial coefficients relative to the probe
            a1_reg   <= AW'(y0) - (AW'(y1) <<< 1) + AW'(y2);
            h1_reg   <= HW'(y1) - HW'(y0);
            c1_reg   <= y0;
            x01_reg  <= XW'(sx) - XW'(px);
            thx1_reg <= (TW'(cx) - TW'(sx)) <<< 1;
            ax1_reg  <= TW'(sx) - (TW'(cx) <<< 1) + TW'(ex);
            // squares and cross product
            hh2_reg  <= h1_reg * h1_reg;
            ac2_reg  <= a1_reg * c1_reg;
            a2_reg   <= a1_reg;
            h2_reg   <= h1_reg;
            c2_reg   <= c1_reg;
            x02_reg  <= x01_reg;
            thx2_reg <= thx1_reg;
            ax2_reg  <= ax1_reg;
            // discriminant
            d3_reg   <= PW'(hh2_reg) - PW'(ac2_reg);
            a3_reg   <= a2_reg;
            h3_reg   <= h2_reg;
            c3_reg   <= c2_reg;
            x03_reg  <= x02_reg;
            thx3_reg <= thx2_reg;
            ax3_reg  <= ax2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_disc  = d3_reg;
    assign out_a     = a3_reg;
    assign out_h     = h3_reg;
    assign out_c     = c3_reg;
    assign out_x0    = x03_reg;
    assign out_twohx = thx3_reg;
    assign out_ax    = ax3_reg;

endmodule

// File: rtl/core/qbrc_sqrt.sv
module qbrc_sqrt #(
    parameter int IN_W   = 52,
    parameter int OUT_W  = 26,
    parameter int SIDE_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [IN_W-1:0]   in_rad,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [OUT_W-1:0]  out_root,
    output logic [SIDE_W-1:0] out_side
);

    // one result bit per stage, msb first; rem holds radicand minus root squared
    logic              vld_reg  [OUT_W];
    logic [IN_W-1:0]   rem_reg  [OUT_W];
    logic [OUT_W-1:0]  root_reg [OUT_W];
    logic [SIDE_W-1:0] side_reg [OUT_W];

    for (genvar i = 0; i < OUT_W; i++) begin : g_stage
        localparam int B = OUT_W - 1 - i;
        logic              v_in;
        logic [IN_W-1:0]   r_in;
        logic [OUT_W-1:0]  q_in;
        logic [SIDE_W-1:0] s_in;
        logic [IN_W:0]     trial;
        logic              take;

        if (i == 0) begin : g_first
            assign v_in = in_valid;
            assign r_in = in_rad;
            assign q_in = '0;
            assign s_in = in_side;
        end else begin : g_next
            assign v_in = vld_reg[i-1];
            assign r_in = rem_reg[i-1];
            assign q_in = root_reg[i-1];
            assign s_in = side_reg[i-1];
        end

        assign trial = ((IN_W+1)'(q_in) << (B + 1)) | ((IN_W+1)'(1) << (2 * B));
        assign take  = {1'b0, r_in} >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= take ? r_in - trial[IN_W-1:0] : r_in;
                root_reg[i] <= take ? (q_in | (OUT_W'(1) << B)) : q_in;
                side_reg[i] <= s_in;
            end
        end
    end

    assign out_valid = vld_reg[OUT_W-1];
    assign out_root  = root_reg[OUT_W-1];
    assign out_side  = side_reg[OUT_W-1];

endmodule

// File: rtl/core/qbrc_root.sv
module qbrc_root
    import qbrc_pkg::*;
#(
    parameter int CW = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  lane_t                in_flag,
    input  logic signed [CW+3:0] in_num,
    input  logic signed [CW+3:0] in_den,
    input  logic signed [CW:0]   in_x0,
    input  logic signed [CW+1:0] in_twohx,
    input  logic signed [CW+1:0] in_ax,
    output lane_t                out_flag
);

    localparam int NW  = CW + 4;
    localparam int MW  = CW + 3;
    localparam int XW  = CW + 1;
    localparam int TW  = CW + 2;
    localparam int P1W = TW + QW + 1;
    localparam int IW  = TW + 1;
    localparam int P2W = IW + QW + 1;
    localparam int DXW = CW + 6;

    // sign fix and range test of num/den
    logic signed [NW-1:0] n_fix, d_fix;
    logic                 in_ok;

    assign n_fix = in_den[NW-1] ? -in_num : in_num;
    assign d_fix = in_den[NW-1] ? -in_den : in_den;
    assign in_ok = in_flag.live && !n_fix[NW-1] && (n_fix <= d_fix);

    logic                 v0_reg, ok0_reg;
    logic [MW-1:0]        nm0_reg, dm0_reg;
    logic signed [XW-1:0] x00_reg;
    logic signed [TW-1:0] thx0_reg, ax0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_flag.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ok0_reg  <= in_ok;
            nm0_reg  <= n_fix[MW-1:0];
            dm0_reg  <= d_fix[MW-1:0];
            x00_reg  <= in_x0;
            thx0_reg <= in_twohx;
            ax0_reg  <= in_ax;
        end
    end

    // restoring division, one quotient bit per stage, msb first
    logic                 dv_reg  [QW];
    logic                 dok_reg [QW];
    logic [MW-1:0]        drem_reg[QW];
    logic [MW-1:0]        dden_reg[QW];
    logic [QW-1:0]        dq_reg  [QW];
    logic signed [XW-1:0] dx0_reg [QW];
    logic signed [TW-1:0] dthx_reg[QW];
    logic signed [TW-1:0] dax_reg [QW];

    for (genvar i = 0; i < QW; i++) begin : g_div
        logic                 v_in, ok_in;
        logic [MW-1:0]        r_in, d_in;
        logic [QW-1:0]        q_in;
        logic signed [XW-1:0] x0_in;
        logic signed [TW-1:0] thx_in, ax_in;
        logic [MW:0]          sh;
        logic [MW:0]          diff;
        logic                 take;

        if (i == 0) begin : g_first
            assign v_in   = v0_reg;
            assign ok_in  = ok0_reg;
            assign r_in   = nm0_reg;
            assign d_in   = dm0_reg;
            assign q_in   = '0;
            assign x0_in  = x00_reg;
            assign thx_in = thx0_reg;
            assign ax_in  = ax0_reg;
            assign sh     = {1'b0, r_in};
        end else begin : g_next
            assign v_in   = dv_reg[i-1];
            assign ok_in  = dok_reg[i-1];
            assign r_in   = drem_reg[i-1];
            assign d_in   = dden_reg[i-1];
            assign q_in   = dq_reg[i-1];
            assign x0_in  = dx0_reg[i-1];
            assign thx_in = dthx_reg[i-1];
            assign ax_in  = dax_reg[i-1];
            assign sh     = {r_in, 1'b0};
        end

        assign take = sh >= {1'b0, d_in};
        assign diff = sh - {1'b0, d_in};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[i] <= 1'b0;
            end else if (en) begin
                dv_reg[i] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dok_reg[i]  <= ok_in;
                drem_reg[i] <= take ? diff[MW-1:0] : sh[MW-1:0];
                dden_reg[i] <= d_in;
                dq_reg[i]   <= {q_in[QW-2:0], take};
                dx0_reg[i]  <= x0_in;
                dthx_reg[i] <= thx_in;
                dax_reg[i]  <= ax_in;
            end
        end
    end

    // horner evaluation of the curve x at t
    logic                  v1_reg, v2_reg, v3_reg, v4_reg;
    logic                  ok1_reg, ok2_reg, ok3_reg, hit4_reg;
    logic [QW-1:0]         t1_reg, t2_reg;
    logic signed [XW-1:0]  x01_reg, x02_reg, x03_reg;
    logic signed [TW-1:0]  thx1_reg;
    logic signed [P1W-1:0] p1_reg;
    logic signed [IW-1:0]  inner2_reg;
    logic signed [P2W-1:0] p2_reg;
    logic signed [DXW-1:0] dx;

    assign dx = DXW'(x03_reg) + DXW'(p2_reg >>> TFRAC);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= dv_reg[QW-1];
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg     <= dax_reg[QW-1] * $signed({1'b0, dq_reg[QW-1]});
            t1_reg     <= dq_reg[QW-1];
            ok1_reg    <= dok_reg[QW-1];
            x01_reg    <= dx0_reg[QW-1];
            thx1_reg   <= dthx_reg[QW-1];
            inner2_reg <= IW'(thx1_reg) + IW'(p1_reg >>> TFRAC);
            t2_reg     <= t1_reg;
            ok2_reg    <= ok1_reg;
            x02_reg    <= x01_reg;
            p2_reg     <= inner2_reg * $signed({1'b0, t2_reg});
            ok3_reg    <= ok2_reg;
            x03_reg    <= x02_reg;
            hit4_reg   <= ok3_reg && !dx[DXW-1] && (dx != '0);
        end
    end

    assign out_flag.valid = v4_reg;
    assign out_flag.live  = hit4_reg;

endmodule

// File: rtl/core/quad_bezier_ray_crossings.sv
// channel  | dir | ports            | word contents (lsb first)
// ---------+-----+------------------+--------------------------------------------------
// s_       | in  | tvalid/tready    | start_x start_y ctrl_x ctrl_y end_x end_y
//          |     | tdata 8*COORD    | probe_x probe_y, COORD_BITS each, signed
// m_       | out | tvalid/tready    | crossing_count [1:0], zeros above
//
// one word in and one word out per cycle when the output is taken
// pipe depth is set mostly by the bit-serial square root
// (COORD_BITS + 2 stages) and the 17-stage divider for the root t
// aresetn is synchronous; it clears the valid bits only, data needs no reset
// a stall at m_ freezes every stage at once and s_tready falls with it
module quad_bezier_ray_crossings
    import qbrc_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // start_x, start_y, ctrl_x, ctrl_y, end_x, end_y, probe_x, probe_y
    input  logic [8*COORD_BITS-1:0] s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // crossing_count [1:0], zero padding [7:2]
    output logic [M_DATA_W-1:0]     m_tdata
);

    localparam int CW     = COORD_BITS;
    localparam int AW     = CW + 3;
    localparam int HW     = CW + 2;
    localparam int YW     = CW + 1;
    localparam int XW     = CW + 1;
    localparam int TW     = CW + 2;
    localparam int PW     = 2 * CW + 5;
    localparam int DW     = 2 * CW + 4;
    localparam int SW     = CW + 2;
    localparam int NW     = CW + 4;
    localparam int SIDE_W = 1 + AW + HW + YW + XW + TW + TW;

    // whole pipe moves together; it holds only when a result waits unread
    logic en;
    logic out_valid_reg;
    logic [COUNT_W-1:0] count_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    // coefficients and discriminant
    logic                 st_valid;
    logic signed [PW-1:0] st_disc;
    logic signed [AW-1:0] st_a;
    logic signed [HW-1:0] st_h;
    logic signed [YW-1:0] st_c;
    logic signed [XW-1:0] st_x0;
    logic signed [TW-1:0] st_twohx, st_ax;

    qbrc_setup #(.CW(CW)) u_setup (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .out_valid (st_valid),
        .out_disc  (st_disc),
        .out_a     (st_a),
        .out_h     (st_h),
        .out_c     (st_c),
        .out_x0    (st_x0),
        .out_twohx (st_twohx),
        .out_ax    (st_ax)
    );

    // floor square root of the discriminant, negative case carried as a flag
    logic              disc_neg;
    logic [DW-1:0]     rad;
    logic              sq_valid;
    logic [SW-1:0]     sq_root;
    logic [SIDE_W-1:0] sq_side;

    assign disc_neg = st_disc[PW-1];
    assign rad      = disc_neg ? '0 : st_disc[DW-1:0];

    qbrc_sqrt #(.IN_W(DW), .OUT_W(SW), .SIDE_W(SIDE_W)) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (st_valid),
        .in_rad    (rad),
        .in_side   ({disc_neg, st_a, st_h, st_c, st_x0, st_twohx, st_ax}),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    logic                 q_neg;
    logic signed [AW-1:0] q_a;
    logic signed [HW-1:0] q_h;
    logic signed [YW-1:0] q_c;
    logic signed [XW-1:0] q_x0;
    logic signed [TW-1:0] q_twohx, q_ax;

    assign {q_neg, q_a, q_h, q_c, q_x0, q_twohx, q_ax} = sq_side;

    // root selection: linear, no root, double root or two roots
    logic signed [NW-1:0] s_ext, neg_h;
    logic signed [NW-1:0] num0, num1, den0;
    logic                 go0, go1;

    assign s_ext = NW'($signed({1'b0, sq_root}));
    assign neg_h = -NW'(q_h);

    always_comb begin
        num0 = neg_h + s_ext;
        num1 = neg_h - s_ext;
        den0 = NW'(q_a);
        go0  = 1'b0;
        go1  = 1'b0;
        if (q_a == '0) begin
            // straight line in y: single root -c/(2h), flat curve gives none
            num0 = -NW'(q_c);
            den0 = NW'(q_h) <<< 1;
            go0  = (q_h != '0);
        end else if (!q_neg) begin
            go0 = 1'b1;
            go1 = (sq_root != '0);
        end
    end

    logic                 sel_valid_reg;
    logic                 go0_reg, go1_reg;
    logic signed [NW-1:0] num0_reg, num1_reg, den0_reg, den1_reg;
    logic signed [XW-1:0] x0_reg;
    logic signed [TW-1:0] twohx_reg, ax_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_valid_reg <= 1'b0;
        end else if (en) begin
            sel_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            go0_reg   <= go0;
            go1_reg   <= go1;
            num0_reg  <= num0;
            num1_reg  <= num1;
            den0_reg  <= den0;
            den1_reg  <= NW'(q_a);
            x0_reg    <= q_x0;
            twohx_reg <= q_twohx;
            ax_reg    <= q_ax;
        end
    end

    // two root lanes in step
    lane_t lane0_in, lane1_in, lane0_out, lane1_out;

    assign lane0_in.valid = sel_valid_reg;
    assign lane0_in.live  = go0_reg;
    assign lane1_in.valid = sel_valid_reg;
    assign lane1_in.live  = go1_reg;

    qbrc_root #(.CW(CW)) u_root0 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_flag  (lane0_in),
        .in_num   (num0_reg),
        .in_den   (den0_reg),
        .in_x0    (x0_reg),
        .in_twohx (twohx_reg),
        .in_ax    (ax_reg),
        .out_flag (lane0_out)
    );

    qbrc_root #(.CW(CW)) u_root1 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_flag  (lane1_in),
        .in_num   (num1_reg),
        .in_den   (den1_reg),
        .in_x0    (x0_reg),
        .in_twohx (twohx_reg),
        .in_ax    (ax_reg),
        .out_flag (lane1_out)
    );

    // output register, the word waits here while m_tready is low
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= lane0_out.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            count_reg <= COUNT_W'(lane0_out.live) + COUNT_W'(lane1_out.live);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - COUNT_W){1'b0}}, count_reg};

`ifndef SYNTH
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[COUNT_W-1:0] != 2'd3))
        else $error("crossing count out of range");

    a_lanes_in_step: assert property (@(posedge aclk) disable iff (!aresetn)
        lane0_out.valid == lane1_out.valid)
        else $error("root lanes out of step");

    a_second_needs_first: assert property (@(posedge aclk) disable iff (!aresetn)
        go1_reg |-> go0_reg)
        else $error("second root lane live without the first");

    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(sel_valid_reg) && $stable(lane0_out.valid))
        else $error("pipe moved during stall");
`endif

endmodule
